/* hdl/position_velocity_interpolator_defines.svh */
// assertion macros for the position velocity interpolator checker
// used by pvi_checker.sv, no other dependencies
`ifndef POSITION_VELOCITY_INTERPOLATOR_DEFINES_SVH
`define POSITION_VELOCITY_INTERPOLATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PVI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pvi assertion failed");

// next-cycle implication, disabled during reset
`define PVI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pvi assertion failed");

`endif

/* hdl/pvi_pkg.sv */
// shared types and constants for the position velocity interpolator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pvi_pkg;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG_TICKS = 1'b1;

    localparam logic [31:0] TICK_PERIOD_RESET = 32'd858993;
    localparam logic [15:0] WATCHDOG_RESET    = 16'd10;
    localparam logic [31:0] RATE_ONE          = 32'd65536;
    localparam logic [31:0] RATE_RESET        = 32'd65536000;
    localparam logic [31:0] RATE_MAX          = 32'hFFFF_FFFF;
    localparam logic [15:0] IDLE_MAX          = 16'hFFFF;
    localparam logic [15:0] FILT_NEW          = 16'd66;
    localparam logic [15:0] FILT_OLD          = 16'd65470;
    localparam logic [48:0] FILT_ROUND        = 49'h8000;

    typedef struct packed {
        logic signed [31:0] angle_cmd;
        logic signed [47:0] velocity_cmd;
    } in_t;

    typedef struct packed {
        logic signed [31:0] angle_out;
        logic signed [47:0] velocity_out;
        logic               watchdog_error;
        logic [31:0]        command_rate;
    } out_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_HI   = 5'b00010,
        ST_RATE = 5'b00100,
        ST_DEC  = 5'b01000,
        ST_FILT = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        MUL_VEL_LO = 2'b00,
        MUL_VEL_HI = 2'b01,
        MUL_RATE   = 2'b10
    } mul_sel_t;

    typedef struct packed {
        logic     accept;
        mul_sel_t mul_sel;
        logic     lo_load;
        logic     angle_upd;
        logic     rate_dec;
        logic     out_load;
    } cmd_t;

endpackage

`default_nettype wire

/* hdl/pvi_ctrl.sv */
// sequencer for the position velocity interpolator
// depends on pvi_pkg
`timescale 1ns / 1ps
`default_nettype none

module pvi_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    output pvi_pkg::cmd_t     cmd
);

    pvi_pkg::state_t state_reg;
    pvi_pkg::state_t state_next;
    logic            m_valid_reg;
    logic            m_valid_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == pvi_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd           = '0;
        cmd.mul_sel   = pvi_pkg::MUL_VEL_LO;
        state_next    = state_reg;
        unique case (state_reg)
            pvi_pkg::ST_IDLE: begin
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = pvi_pkg::ST_HI;
                end
            end
            pvi_pkg::ST_HI: begin
                cmd.mul_sel = pvi_pkg::MUL_VEL_HI;
                cmd.lo_load = 1'b1;
                state_next  = pvi_pkg::ST_RATE;
            end
            pvi_pkg::ST_RATE: begin
                cmd.mul_sel   = pvi_pkg::MUL_RATE;
                cmd.angle_upd = 1'b1;
                state_next    = pvi_pkg::ST_DEC;
            end
            pvi_pkg::ST_DEC: begin
                cmd.rate_dec = 1'b1;
                state_next   = pvi_pkg::ST_FILT;
            end
            pvi_pkg::ST_FILT: begin
                cmd.out_load = out_free;
                if (out_free) begin
                    state_next = pvi_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pvi_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pvi_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/pvi_datapath.sv */
// state registers, shared 32x32 multiplier, filter and result word register
// depends on pvi_pkg
`timescale 1ns / 1ps
`default_nettype none

module pvi_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [pvi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pvi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire pvi_pkg::in_t                    s_data,
    input  wire pvi_pkg::cmd_t                   cmd,
    output pvi_pkg::out_t                        m_data
);

    logic [31:0]        tick_period_reg;
    logic [15:0]        watchdog_reg;
    logic [31:0]        angle_acc_reg;
    logic [31:0]        last_cmd_reg;
    logic [15:0]        idle_reg;
    logic [15:0]        idle_next;
    logic [31:0]        rate_raw_reg;
    logic [31:0]        rate_raw_next;
    logic [31:0]        smooth_reg;
    logic signed [47:0] vel_reg;
    logic               err_reg;
    logic               change_reg;
    logic [63:0]        mul_reg;
    logic [63:0]        lo_reg;
    pvi_pkg::out_t      out_reg;

    logic               trip;
    logic               change;
    logic signed [47:0] vel_eff;
    logic [31:0]        mul_a;
    logic [63:0]        mul_prod;
    logic [31:0]        angle_step;
    logic [31:0]        rate_step;
    logic [48:0]        filt_sum;
    logic [31:0]        filt;

    // watchdog and command change test on the incoming word
    assign trip    = (idle_reg > watchdog_reg) && (s_data.velocity_cmd != 48'sd0);
    assign change  = (s_data.angle_cmd != last_cmd_reg);
    assign vel_eff = trip ? 48'sd0 : s_data.velocity_cmd;

    always_comb begin
        idle_next = idle_reg;
        if (change) begin
            idle_next = 16'd0;
        end else if (!trip && idle_reg != pvi_pkg::IDLE_MAX) begin
            idle_next = idle_reg + 16'd1;
        end
    end

    always_comb begin
        rate_raw_next = rate_raw_reg + pvi_pkg::RATE_ONE;
        if (rate_raw_reg > pvi_pkg::RATE_MAX - pvi_pkg::RATE_ONE) begin
            rate_raw_next = pvi_pkg::RATE_MAX;
        end
    end

    // shared multiplier, operand b is always the tick period
    always_comb begin
        unique case (cmd.mul_sel)
            pvi_pkg::MUL_VEL_LO: mul_a = vel_eff[31:0];
            pvi_pkg::MUL_VEL_HI: mul_a = {{16{vel_reg[47]}}, vel_reg[47:32]};
            pvi_pkg::MUL_RATE:   mul_a = rate_raw_reg;
            default:             mul_a = '0;
        endcase
    end

    assign mul_prod   = 64'(mul_a) * 64'(tick_period_reg);
    // rounded bits 63:32 of the 80 bit velocity product
    assign angle_step = lo_reg[63:32] + mul_reg[31:0] + 32'(lo_reg[31]);
    assign rate_step  = mul_reg[63:32] + 32'(mul_reg[31]);
    assign filt_sum   = 49'(rate_raw_reg) * 49'(pvi_pkg::FILT_NEW)
                      + 49'(smooth_reg) * 49'(pvi_pkg::FILT_OLD)
                      + pvi_pkg::FILT_ROUND;
    assign filt       = filt_sum[47:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_period_reg <= pvi_pkg::TICK_PERIOD_RESET;
            watchdog_reg    <= pvi_pkg::WATCHDOG_RESET;
            angle_acc_reg   <= '0;
            last_cmd_reg    <= '0;
            idle_reg        <= '0;
            rate_raw_reg    <= pvi_pkg::RATE_RESET;
            smooth_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    pvi_pkg::CFG_TICK_PERIOD:    tick_period_reg <= cfg_wdata;
                    pvi_pkg::CFG_WATCHDOG_TICKS: watchdog_reg    <= cfg_wdata[15:0];
                    default:                     watchdog_reg    <= watchdog_reg;
                endcase
            end
            if (cmd.accept) begin
                idle_reg     <= idle_next;
                last_cmd_reg <= s_data.angle_cmd;
                if (change) begin
                    angle_acc_reg <= s_data.angle_cmd;
                    rate_raw_reg  <= rate_raw_next;
                end
            end
            if (cmd.angle_upd && !change_reg) begin
                angle_acc_reg <= angle_acc_reg + angle_step;
            end
            if (cmd.rate_dec) begin
                rate_raw_reg <= rate_raw_reg - rate_step;
            end
            if (cmd.out_load) begin
                smooth_reg <= filt;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        mul_reg <= mul_prod;
        if (cmd.accept) begin
            vel_reg    <= vel_eff;
            err_reg    <= trip;
            change_reg <= change;
        end
        if (cmd.lo_load) begin
            lo_reg <= mul_reg;
        end
        if (cmd.out_load) begin
            out_reg.angle_out      <= angle_acc_reg;
            out_reg.velocity_out   <= vel_reg;
            out_reg.watchdog_error <= err_reg;
            out_reg.command_rate   <= filt;
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

/* hdl/position_velocity_interpolator.sv */
// top level of the position velocity interpolator
// depends on pvi_pkg, pvi_ctrl and pvi_datapath
//
// usage
// - s_ channel takes one word per servo tick: commanded angle (full turn is
//   2^32) and feedforward velocity; m_ channel returns one word per input
//   word: interpolated angle, applied velocity, watchdog flag, command rate
// - cfg_wr_en writes cfg_wdata into register cfg_index at once: 0 is the tick
//   period (unsigned Q0.32 s), 1 the watchdog limit in ticks
// - one word at a time: no new input word is taken until the last one has
//   passed all its steps; the shared 32x32 multiplier takes three passes per
//   word (velocity low half, velocity high half, rate decay), followed by a
//   decay step and the rate filter step, which loads the result register
// - the next input word is taken while the last result waits on m_ready;
//   a stalled receiver holds m_data and m_valid, and the block then waits
//   at its final step until the result register is free
// - reset: angle, last command, idle count and filtered rate clear, raw rate
//   returns to 1000 Hz, registers return to their defaults, m_valid drops
`timescale 1ns / 1ps
`default_nettype none

module position_velocity_interpolator (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [pvi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pvi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire pvi_pkg::in_t                    s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output pvi_pkg::out_t                        m_data
);

    pvi_pkg::cmd_t cmd;

    pvi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    pvi_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

/* hdl/pvi_checker.sv */
// port level checks for the position velocity interpolator, bound to the top
// depends on pvi_pkg and position_velocity_interpolator_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "position_velocity_interpolator_defines.svh"

module pvi_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire pvi_pkg::out_t m_data
);

    logic s_fire;

    assign s_fire = s_valid && s_ready;

    // stalled result word holds
    `PVI_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    // one word in flight at a time
    `PVI_ASSERT_NXT(a_busy_after_accept, s_fire, !s_ready)
    // a tripped watchdog always reports zero velocity
    `PVI_ASSERT_IMP(a_trip_zero_vel, m_valid && m_data.watchdog_error,
        m_data.velocity_out == 48'sd0)
    // a new result only appears at the end of a word's work
    `PVI_ASSERT_IMP(a_result_from_work, $rose(m_valid), $past(!s_ready))

endmodule

bind position_velocity_interpolator pvi_checker u_pvi_checker (.*);

`default_nettype wire
